[hw/rtl/mpf_pkg.sv]
package mpf_pkg;

	// Defaults for the top-level parameters.
	localparam int MAX_PAYLOAD_DWORDS_DEF = 32;
	localparam int FRAME_TYPE_DEF = 8;

	// Field widths of one input item.
	localparam int OFFSET_W = 21;
	localparam int BYTES_W = 9;
	localparam int DWORD_W = 64;
	localparam int WORD_W = 32;
	localparam int IN_DATA_W = 192;

	// Size table geometry.
	localparam int SIZE_ENTRIES = 32;
	localparam int SIZE_IDX_W = 5;

	// Item kinds carried in the input tuser.
	localparam logic OP_HEADER = 1'b0;
	localparam logic OP_PAYLOAD = 1'b1;

	// Transaction codes.
	localparam logic [1:0] TR_READ_REQ = 2'd0;
	localparam logic [1:0] TR_WRITE_REQ = 2'd1;
	localparam logic [1:0] TR_READ_RESP = 2'd2;
	localparam logic [1:0] TR_WRITE_RESP = 2'd3;

	// Error codes carried in the output tuser.
	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_SIZE,
		ERR_PAYLOAD
	} err_t;

	// One unpacked input word.
	typedef struct packed {
		logic                op;
		logic [1:0]          transaction;
		logic [1:0]          priority_req;
		logic [1:0]          transport_type;
		logic [7:0]          dest_id;
		logic [7:0]          source_id;
		logic [7:0]          tag;
		logic [OFFSET_W-1:0] cfg_offset;
		logic [BYTES_W-1:0]  size_bytes;
		logic [DWORD_W-1:0]  size_mask;
		logic [3:0]          status;
		logic [DWORD_W-1:0]  payload;
	} item_t;

	// One output word with its marks.
	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic              last;
		err_t              error;
	} res_t;

	// Size table: byte count and lane mask for each size code.
	localparam logic [BYTES_W-1:0] SIZE_TAB_BYTES [SIZE_ENTRIES] = '{
		9'd1, 9'd1, 9'd1, 9'd1, 9'd2, 9'd3, 9'd2, 9'd5,
		9'd4, 9'd6, 9'd7, 9'd8, 9'd32, 9'd96, 9'd160, 9'd224,
		9'd1, 9'd1, 9'd1, 9'd1, 9'd2, 9'd3, 9'd2, 9'd5,
		9'd4, 9'd6, 9'd7, 9'd16, 9'd64, 9'd128, 9'd192, 9'd256
	};

	localparam logic [DWORD_W-1:0] SIZE_TAB_MASK [SIZE_ENTRIES] = '{
		64'hFF00_0000_0000_0000, 64'h00FF_0000_0000_0000,
		64'h0000_FF00_0000_0000, 64'h0000_00FF_0000_0000,
		64'hFFFF_0000_0000_0000, 64'hFFFF_FF00_0000_0000,
		64'h0000_FFFF_0000_0000, 64'hFFFF_FFFF_FF00_0000,
		64'hFFFF_FFFF_0000_0000, 64'hFFFF_FFFF_FFFF_0000,
		64'hFFFF_FFFF_FFFF_FF00, 64'hFFFF_FFFF_FFFF_FFFF,
		64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
		64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
		64'h0000_0000_FF00_0000, 64'h0000_0000_00FF_0000,
		64'h0000_0000_0000_FF00, 64'h0000_0000_0000_00FF,
		64'h0000_0000_FFFF_0000, 64'h0000_0000_00FF_FFFF,
		64'h0000_0000_0000_FFFF, 64'h0000_00FF_FFFF_FFFF,
		64'h0000_0000_FFFF_FFFF, 64'h0000_FFFF_FFFF_FFFF,
		64'h00FF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
		64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
		64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF
	};

endpackage

[hw/rtl/maint_packet_framer_core.sv]
// An accepted word is registered in stage one, then its result words in the result buffer,
// which offers the first output word and holds it while the receiver stalls.
// An item yields two words, an error item one; the one-word output channel sets the rate,
// and a new item loads as the last word of the one before leaves.
// Reset: arst_n clears the stage valid flags and the payload count at once.
module maint_packet_framer_core #(
	parameter int MAX_PAYLOAD_DWORDS = mpf_pkg::MAX_PAYLOAD_DWORDS_DEF,
	parameter int FRAME_TYPE = mpf_pkg::FRAME_TYPE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// transaction, priority_req, transport_type, dest_id, source_id, tag,
	// cfg_offset, size_bytes, size_mask, status, payload
	input  logic [mpf_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                           s_tuser,  // op
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [mpf_pkg::WORD_W-1:0]     m_tdata,  // word
	output logic                           m_tlast,  // last
	output logic [1:0]                     m_tuser   // error
);

	mpf_pkg::item_t item_in;
	mpf_pkg::item_t item_s1;
	logic valid_s1;
	logic load;
	logic free;
	logic pair;
	mpf_pkg::res_t res_first;
	mpf_pkg::res_t res_second;

	// Unpack the input word.
	always_comb begin
		item_in.op = s_tuser;
		item_in.transaction = s_tdata[1:0];
		item_in.priority_req = s_tdata[3:2];
		item_in.transport_type = s_tdata[5:4];
		item_in.dest_id = s_tdata[13:6];
		item_in.source_id = s_tdata[21:14];
		item_in.tag = s_tdata[29:22];
		item_in.cfg_offset = s_tdata[50:30];
		item_in.size_bytes = s_tdata[59:51];
		item_in.size_mask = s_tdata[123:60];
		item_in.status = s_tdata[127:124];
		item_in.payload = s_tdata[191:128];
	end

	assign load = valid_s1 && free;
	assign s_tready = !valid_s1 || load;

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= item_in;
		end
	end

	mpf_encoder #(
		.MAX_PAYLOAD_DWORDS (MAX_PAYLOAD_DWORDS),
		.FRAME_TYPE         (FRAME_TYPE)
	) u_encoder (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_s1),
		.load       (load),
		.res_first  (res_first),
		.res_second (res_second),
		.pair       (pair)
	);

	mpf_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (load),
		.pair       (pair),
		.res_first  (res_first),
		.res_second (res_second),
		.free       (free),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tlast    (m_tlast),
		.m_tuser    (m_tuser)
	);

`ifndef SYNTH
	// An error word is always a lone zero word marked last.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != mpf_pkg::ERR_NONE) |-> (m_tlast && m_tdata == '0))
		else $error("error word not zero or not marked last");

	// A registered item waiting for the result buffer is neither lost nor changed.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !load) |=> (valid_s1 && $stable(item_s1)))
		else $error("stage one item lost while stalled");

	// Loading the result buffer always offers a word in the next cycle.
	a_load_out: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> m_tvalid)
		else $error("loaded results not offered");

	// A word held back by the receiver stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=>
			(m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
		else $error("stalled output word dropped or changed");
`endif

endmodule

[hw/rtl/mpf_size_lookup.sv]
module mpf_size_lookup (
	input  logic [mpf_pkg::BYTES_W-1:0]    size_bytes,
	input  logic [mpf_pkg::DWORD_W-1:0]    size_mask,
	output logic                           hit,
	output logic [mpf_pkg::SIZE_IDX_W-1:0] idx
);

	logic [mpf_pkg::SIZE_ENTRIES-1:0] match;

	// Compare the pair against every table entry; the pairs in the table are unique.
	always_comb begin
		for (int i = 0; i < mpf_pkg::SIZE_ENTRIES; i++) begin
			match[i] = (mpf_pkg::SIZE_TAB_BYTES[i] == size_bytes) &&
				(mpf_pkg::SIZE_TAB_MASK[i] == size_mask);
		end
	end

	// Encode the single matching entry into its size index.
	always_comb begin
		idx = '0;
		for (int i = 0; i < mpf_pkg::SIZE_ENTRIES; i++) begin
			if (match[i]) begin
				idx = idx | mpf_pkg::SIZE_IDX_W'(i);
			end
		end
	end

	assign hit = |match;

endmodule

[hw/rtl/mpf_encoder.sv]
module mpf_encoder #(
	parameter int MAX_PAYLOAD_DWORDS = mpf_pkg::MAX_PAYLOAD_DWORDS_DEF,
	parameter int FRAME_TYPE = mpf_pkg::FRAME_TYPE_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mpf_pkg::item_t item,
	input  logic           load,
	output mpf_pkg::res_t  res_first,
	output mpf_pkg::res_t  res_second,
	output logic           pair
);

	localparam int DW_W = $clog2(MAX_PAYLOAD_DWORDS + 1);
	localparam logic [6:0] MAX_CNT = 7'(MAX_PAYLOAD_DWORDS);

	logic [DW_W-1:0] dwords_left_q;
	logic [DW_W-1:0] dwords_next;
	logic [DW_W-1:0] left_dec;
	logic [9:0] cnt_sum;
	logic [6:0] cnt_raw;
	logic [6:0] cnt;
	logic [6:0] rd_cnt;
	logic hit;
	logic [mpf_pkg::SIZE_IDX_W-1:0] idx;
	logic [mpf_pkg::WORD_W-1:0] w0_base;

	mpf_size_lookup u_lookup (
		.size_bytes (item.size_bytes),
		.size_mask  (item.size_mask),
		.hit        (hit),
		.idx        (idx)
	);

	// Payload doublewords still expected for the current packet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwords_left_q <= '0;
		end else if (load) begin
			dwords_left_q <= dwords_next;
		end
	end

	// Doubleword count from the byte count, rounded up.
	assign cnt_sum = {1'b0, item.size_bytes} + 10'd7;
	assign cnt_raw = cnt_sum[9:3];
	assign rd_cnt = (cnt_raw > MAX_CNT) ? MAX_CNT : cnt_raw;
	assign left_dec = dwords_left_q - DW_W'(1);

	// Common part of the first header word; the top nibble is filled per transaction.
	assign w0_base = {4'b0000, 2'b00, item.transaction, item.source_id, item.dest_id,
		4'(FRAME_TYPE), item.transport_type, item.priority_req};

	// Build the words for one item and the next payload count.
	always_comb begin
		res_first = '{word: '0, last: 1'b0, error: mpf_pkg::ERR_NONE};
		res_second = '{word: '0, last: 1'b1, error: mpf_pkg::ERR_NONE};
		pair = 1'b0;
		dwords_next = dwords_left_q;
		cnt = '0;
		if (item.op == mpf_pkg::OP_PAYLOAD) begin
			if (dwords_left_q == '0) begin
				res_second.error = mpf_pkg::ERR_PAYLOAD;
			end else begin
				pair = 1'b1;
				dwords_next = left_dec;
				res_first.word = item.payload[63:32];
				res_second.word = item.payload[31:0];
				res_second.last = (left_dec == '0);
			end
		end else begin
			case (item.transaction)
				mpf_pkg::TR_READ_REQ, mpf_pkg::TR_WRITE_REQ: begin
					if (item.transaction == mpf_pkg::TR_WRITE_REQ) begin
						cnt = cnt_raw;
					end
					if (!hit || cnt > MAX_CNT) begin
						dwords_next = '0;
						res_second.error = mpf_pkg::ERR_SIZE;
					end else begin
						pair = 1'b1;
						dwords_next = DW_W'(cnt);
						res_first.word = {idx[3:0], w0_base[27:0]};
						res_second.word = {2'b00, idx[4], item.cfg_offset, item.tag};
						res_second.last = (cnt == '0);
					end
				end
				mpf_pkg::TR_READ_RESP, mpf_pkg::TR_WRITE_RESP: begin
					if (item.transaction == mpf_pkg::TR_READ_RESP) begin
						cnt = rd_cnt;
					end
					pair = 1'b1;
					dwords_next = DW_W'(cnt);
					res_first.word = {item.status, w0_base[27:0]};
					res_second.word = {24'h0, item.tag};
					res_second.last = (cnt == '0);
				end
				default: begin
					pair = 1'b0;
				end
			endcase
		end
	end

endmodule

[hw/rtl/mpf_out_buf.sv]
module mpf_out_buf (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  logic                        pair,
	input  mpf_pkg::res_t               res_first,
	input  mpf_pkg::res_t               res_second,
	output logic                        free,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [mpf_pkg::WORD_W-1:0]  m_tdata,  // word
	output logic                        m_tlast,
	output logic [1:0]                  m_tuser   // error
);

	mpf_pkg::res_t first_q;
	mpf_pkg::res_t second_q;
	logic [1:0] valid_q;
	logic take;

	assign take = m_tvalid && m_tready;
	// Room for a new item once the buffer is empty or its final word leaves now.
	assign free = (valid_q == 2'b00) || (valid_q == 2'b10 && m_tready);

	// Two-entry result register: the first word drains before the second.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 2'b00;
		end else if (load) begin
			valid_q <= pair ? 2'b11 : 2'b10;
		end else if (take) begin
			valid_q <= valid_q[0] ? 2'b10 : 2'b00;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			first_q <= res_first;
			second_q <= res_second;
		end
	end

	// Present the oldest pending word.
	assign m_tvalid = |valid_q;
	assign m_tdata = valid_q[0] ? first_q.word : second_q.word;
	assign m_tlast = valid_q[0] ? first_q.last : second_q.last;
	assign m_tuser = valid_q[0] ? first_q.error : second_q.error;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
	import mpf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_ITEMS = 1300;
	localparam int DRAIN_LIMIT = 5000;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [IN_DATA_W-1:0] s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [WORD_W-1:0]    m_tdata;
	logic                 m_tlast;
	logic [1:0]           m_tuser;

	// Packet words still owed by the block, oldest first.
	res_t        exp_words[$];
	// Payload doublewords the framer still waits for in the current packet.
	logic [5:0]  dw_pending;
	int unsigned items_sent;
	int          fail_count;
	// When set, that side runs without idle cycles.
	bit          tx_steady;
	bit          rx_steady;

	maint_packet_framer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void push_word(logic [31:0] w, logic l, err_t e);
		res_t r;
		r.word = w;
		r.last = l;
		r.error = e;
		exp_words.push_back(r);
	endfunction

	// Expected packet words for one accepted item; updates the payload count.
	function automatic void predict_words(item_t it);
		int          idx;
		int          cnt;
		logic [31:0] w0;
		logic [31:0] w1;
		if (it.op == OP_PAYLOAD) begin
			if (dw_pending == 6'd0) begin
				push_word(32'd0, 1'b1, ERR_PAYLOAD);
				return;
			end
			dw_pending = dw_pending - 6'd1;
			push_word(it.payload[63:32], 1'b0, ERR_NONE);
			push_word(it.payload[31:0], dw_pending == 6'd0, ERR_NONE);
			return;
		end
		w0 = {4'd0, 2'b00, it.transaction, it.source_id, it.dest_id, 4'(FRAME_TYPE_DEF),
			it.transport_type, it.priority_req};
		if (it.transaction == TR_READ_REQ || it.transaction == TR_WRITE_REQ) begin
			// Requests must name a (bytes, mask) pair from the size table.
			idx = SIZE_ENTRIES;
			for (int i = 0; i < SIZE_ENTRIES; i++) begin
				if (idx == SIZE_ENTRIES && SIZE_TAB_BYTES[i] == it.size_bytes &&
						SIZE_TAB_MASK[i] == it.size_mask)
					idx = i;
			end
			cnt = (it.transaction == TR_WRITE_REQ) ? (int'(it.size_bytes) + 7) / 8 : 0;
			if (idx == SIZE_ENTRIES || cnt > MAX_PAYLOAD_DWORDS_DEF) begin
				dw_pending = 6'd0;
				push_word(32'd0, 1'b1, ERR_SIZE);
				return;
			end
			w0[31:28] = idx[3:0];
			w1 = {2'b00, idx[4], it.cfg_offset, it.tag};
		end else begin
			// Read responses carry payload, saturated at the packet maximum.
			cnt = (it.transaction == TR_READ_RESP) ? (int'(it.size_bytes) + 7) / 8 : 0;
			if (cnt > MAX_PAYLOAD_DWORDS_DEF)
				cnt = MAX_PAYLOAD_DWORDS_DEF;
			w0[31:28] = it.status;
			w1 = {24'd0, it.tag};
		end
		dw_pending = cnt[5:0];
		push_word(w0, 1'b0, ERR_NONE);
		push_word(w1, dw_pending == 6'd0, ERR_NONE);
	endfunction

	function automatic item_t header_item(logic [1:0] tr, logic [8:0] nbytes, logic [63:0] lanes);
		item_t it;
		it = '0;
		it.op = OP_HEADER;
		it.transaction = tr;
		it.size_bytes = nbytes;
		it.size_mask = lanes;
		return it;
	endfunction

	function automatic item_t payload_item(logic [63:0] dword);
		item_t it;
		it = '0;
		it.op = OP_PAYLOAD;
		it.payload = dword;
		return it;
	endfunction

	// A header with random fields. A sound header has a valid size for its kind;
	// otherwise requests get a near-miss or a random size pair.
	function automatic item_t random_header(logic [1:0] tr, bit sound);
		item_t it;
		int    idx;
		it.op = OP_HEADER;
		it.transaction = tr;
		it.priority_req = 2'($urandom);
		it.transport_type = 2'($urandom);
		it.dest_id = 8'($urandom);
		it.source_id = 8'($urandom);
		it.tag = 8'($urandom);
		it.cfg_offset = 21'($urandom);
		it.size_bytes = 9'($urandom);
		it.size_mask = {$urandom, $urandom};
		it.status = 4'($urandom);
		it.payload = {$urandom, $urandom};
		idx = $urandom_range(0, SIZE_ENTRIES - 1);
		if (tr == TR_READ_REQ || tr == TR_WRITE_REQ) begin
			if (sound) begin
				it.size_bytes = SIZE_TAB_BYTES[idx];
				it.size_mask = SIZE_TAB_MASK[idx];
			end else if ($urandom_range(0, 1) == 1) begin
				it.size_bytes = SIZE_TAB_BYTES[idx];
				it.size_mask = SIZE_TAB_MASK[idx] ^ (64'd1 << $urandom_range(0, 63));
			end
		end else if (sound) begin
			// Mostly short responses, now and then up to the full 256 bytes.
			if ($urandom_range(0, 7) == 0)
				it.size_bytes = 9'($urandom_range(0, 256));
			else
				it.size_bytes = 9'($urandom_range(0, 40));
		end
		return it;
	endfunction

	// A payload word whose unused fields still toggle.
	function automatic item_t random_payload();
		item_t it;
		it = random_header(2'($urandom), 1'b0);
		it.op = OP_PAYLOAD;
		return it;
	endfunction

	// Offer one word after a random gap; entered and left at a falling edge.
	task automatic send_word(item_t it);
		int gap;
		gap = tx_steady ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.op;
		s_tdata <= {it.payload, it.status, it.size_mask, it.size_bytes, it.cfg_offset, it.tag,
			it.source_id, it.dest_id, it.transport_type, it.priority_req, it.transaction};
		do @(posedge clk); while (!s_tready);
		predict_words(it);
		items_sent++;
		@(negedge clk);
	endtask

	// Stop sending and let every owed word come out, then settle.
	task automatic wait_all_words();
		int waited;
		waited = 0;
		s_tvalid <= 1'b0;
		while (exp_words.size() != 0 && waited < DRAIN_LIMIT) begin
			@(negedge clk);
			waited++;
		end
		repeat (10) @(negedge clk);
	endtask

	function automatic item_t fields_all_ones(item_t it);
		item_t r;
		r = it;
		r.priority_req = '1;
		r.transport_type = '1;
		r.dest_id = '1;
		r.source_id = '1;
		r.tag = '1;
		r.cfg_offset = '1;
		r.status = '1;
		r.payload = '1;
		return r;
	endfunction

	// Header words alone: every field at both of its extremes.
	task automatic test_header_fields();
		item_t it;
		send_word(header_item(TR_READ_REQ, SIZE_TAB_BYTES[0], SIZE_TAB_MASK[0]));
		it = header_item(TR_READ_REQ, SIZE_TAB_BYTES[SIZE_ENTRIES - 1],
			SIZE_TAB_MASK[SIZE_ENTRIES - 1]);
		send_word(fields_all_ones(it));
		send_word(fields_all_ones(header_item(TR_WRITE_RESP, 9'd0, 64'd0)));
		send_word(header_item(TR_WRITE_RESP, '1, '1));
		wait_all_words();
	endtask

	// Complete packets with payload, including a response with no payload.
	task automatic test_payload_packets();
		send_word(header_item(TR_WRITE_REQ, SIZE_TAB_BYTES[11], SIZE_TAB_MASK[11]));
		send_word(payload_item('1));
		send_word(header_item(TR_READ_RESP, 9'd1, 64'd0));
		send_word(payload_item('0));
		send_word(header_item(TR_READ_RESP, 9'd0, '1));
		send_word(header_item(TR_WRITE_REQ, SIZE_TAB_BYTES[27], SIZE_TAB_MASK[27]));
		send_word(payload_item({$urandom, $urandom}));
		send_word(payload_item({$urandom, $urandom}));
		wait_all_words();
	endtask

	// Bad size pairs, saturated responses, abandoned packets and stray payload.
	task automatic test_error_cases();
		send_word(header_item(TR_READ_REQ, 9'd3, 64'h0000_0000_0000_00FF));
		send_word(header_item(TR_WRITE_REQ, SIZE_TAB_BYTES[7], SIZE_TAB_MASK[8]));
		send_word(header_item(TR_READ_RESP, 9'd511, 64'd0));
		send_word(payload_item({$urandom, $urandom}));
		send_word(payload_item({$urandom, $urandom}));
		// A new header cuts the response short.
		send_word(header_item(TR_WRITE_RESP, 9'd8, 64'd0));
		send_word(payload_item({$urandom, $urandom}));
		// A failed size lookup also drops the pending payload.
		send_word(header_item(TR_WRITE_REQ, SIZE_TAB_BYTES[11], SIZE_TAB_MASK[11]));
		send_word(header_item(TR_READ_REQ, 9'd256, 64'd1));
		send_word(payload_item({$urandom, $urandom}));
		wait_all_words();
	endtask

	// Mostly well-formed packets, with cut packets, stray payload and bad headers.
	task automatic test_random_traffic();
		int unsigned stop_at;
		int unsigned next_drain;
		int          pick;
		logic [1:0]  tr;
		stop_at = items_sent + RANDOM_ITEMS;
		next_drain = items_sent + 300;
		while (items_sent < stop_at) begin
			if ($urandom_range(0, 7) == 0)
				tx_steady = ~tx_steady;
			if ($urandom_range(0, 7) == 0)
				rx_steady = ~rx_steady;
			if (items_sent >= next_drain) begin
				wait_all_words();
				next_drain = items_sent + 300;
			end
			pick = $urandom_range(0, 99);
			tr = 2'($urandom);
			if (pick < 70) begin
				send_word(random_header(tr, 1'b1));
				while (dw_pending != 6'd0)
					send_word(random_payload());
			end else if (pick < 80) begin
				send_word(random_header($urandom_range(0, 1) ? TR_WRITE_REQ : TR_READ_RESP, 1'b1));
				repeat ($urandom_range(0, dw_pending))
					send_word(random_payload());
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 3))
					send_word(random_payload());
			end else begin
				send_word(random_header(tr, 1'b0));
			end
		end
		tx_steady = 1'b0;
		rx_steady = 1'b0;
	endtask

	// Receiver: a random stall before each word, none while rx_steady is set.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			stall = rx_steady ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			@(negedge clk);
		end
	end

	// Compare each word leaving the block with the oldest owed word.
	always @(posedge clk) begin
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (exp_words.size() == 0) begin
				$error("word %h with no packet word owed", m_tdata);
				fail_count++;
			end else begin
				want = exp_words.pop_front();
				if (m_tdata !== want.word) begin
					$error("word: expected %h, got %h", want.word, m_tdata);
					fail_count++;
				end
				if (m_tlast !== want.last) begin
					$error("last: expected %0d, got %0d", want.last, m_tlast);
					fail_count++;
				end
				if (m_tuser !== want.error) begin
					$error("error: expected %0d, got %0d", want.error, m_tuser);
					fail_count++;
				end
			end
		end
	end

	// Hard stop for a hung run.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("maint_packet_framer_core: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		dw_pending = 6'd0;
		items_sent = 0;
		fail_count = 0;
		tx_steady = 1'b0;
		rx_steady = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_header_fields();
		test_payload_packets();
		test_error_cases();
		test_random_traffic();
		wait_all_words();

		if (exp_words.size() != 0) begin
			$error("%0d packet words never came out", exp_words.size());
			fail_count++;
		end
		if (fail_count == 0)
			$display("maint_packet_framer_core: match");
		else
			$display("maint_packet_framer_core: mismatch");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/mpf_pkg.sv
hw/rtl/mpf_size_lookup.sv
hw/rtl/mpf_encoder.sv
hw/rtl/mpf_out_buf.sv
hw/rtl/maint_packet_framer_core.sv
verif/tb_top.sv
